[rtl/crd_pkg.sv]
// Shared types, widths and register indexes for the camera ray direction block.
// No dependencies; every other file of the block imports this package.
package crd_pkg;

    // Vector layout: three signed Q6.14 components per configuration register.
    localparam int NUM_AXES  = 3;
    localparam int COMP_W    = 21;
    localparam int CFG_W     = NUM_AXES * COMP_W;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_DOWN   = 2'd2;

    // Pixel position in 1/16 pixel, and the datapath widths derived from it.
    localparam int POS_W      = 16;
    localparam int FRAC_SHIFT = 4;
    localparam int PROD_W     = COMP_W + POS_W + 1;
    localparam int V_W        = PROD_W + 2;
    localparam int MAG_W      = 38;
    localparam int A_W        = 30;
    localparam int SH_W       = 4;
    localparam int SQ_W       = 2 * A_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int QUO_W      = A_W + 1;
    localparam int ROOT_W     = 16;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int OUT_W      = 16;

    // Unit length in Q1.14.
    localparam logic signed [OUT_W-1:0] ONE_Q14 = 16'sd16384;

    // Pipeline depth: front end, divider, square root, output register.
    localparam int FRONT_STAGES = 6;
    localparam int PIPE_LAT     = FRONT_STAGES + QUO_W + ROOT_W + 1;

    // One input transaction.
    typedef struct packed {
        logic [POS_W-1:0] column_pos;
        logic [POS_W-1:0] row_pos;
    } ray_req_t;

    // One result transaction.
    typedef struct packed {
        logic signed [OUT_W-1:0] dir_x;
        logic signed [OUT_W-1:0] dir_y;
        logic signed [OUT_W-1:0] dir_z;
    } ray_dir_t;

    // Control that travels down the pipeline beside the data.
    typedef struct packed {
        logic                valid;
        logic                zero;
        logic [NUM_AXES-1:0] neg;
    } ray_ctl_t;

    typedef logic [NUM_AXES-1:0][SQ_W-1:0]   sq_vec_t;
    typedef logic [NUM_AXES-1:0][QUO_W-1:0]  quo_vec_t;
    typedef logic [NUM_AXES-1:0][ROOT_W-1:0] root_vec_t;

endpackage

[rtl/camera_ray_direction.sv]
// Pinhole camera ray direction unit, top level; uses crd_pkg, crd_div_pipe, crd_sqrt_pipe.
// A transaction passes from the accepting edge to the done strobe through 6 front-end stages,
// 31 divider stages, 16 square-root stages and the output register.
// Throughput: one transaction per cycle; busy stays low and the receiver cannot stall.
// Reset clears the configuration registers and every valid bit of the pipeline.
module camera_ray_direction (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  crd_pkg::ray_req_t                 request,
    output logic                              done,
    output crd_pkg::ray_dir_t                 result,
    input  logic                              cfg_we,
    input  logic [crd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [crd_pkg::CFG_W-1:0]         cfg_data
);
    import crd_pkg::*;

    // Configuration registers.
    logic [CFG_W-1:0] base_offset_reg;
    logic [CFG_W-1:0] step_right_reg;
    logic [CFG_W-1:0] step_down_reg;

    logic signed [COMP_W-1:0] comp_base  [NUM_AXES];
    logic signed [COMP_W-1:0] comp_right [NUM_AXES];
    logic signed [COMP_W-1:0] comp_down  [NUM_AXES];

    // Front-end pipeline.
    ray_ctl_t                 s1_ctl_reg, s2_ctl_reg, s3_ctl_reg, s4_ctl_reg;
    ray_ctl_t                 s5_ctl_reg, s6_ctl_reg;
    ray_ctl_t                 s3_ctl_next, s4_ctl_next;
    logic signed [PROD_W-1:0] s1_prod_r_reg  [NUM_AXES];
    logic signed [PROD_W-1:0] s1_prod_r_next [NUM_AXES];
    logic signed [PROD_W-1:0] s1_prod_d_reg  [NUM_AXES];
    logic signed [PROD_W-1:0] s1_prod_d_next [NUM_AXES];
    logic signed [V_W-1:0]    s2_v_reg       [NUM_AXES];
    logic signed [V_W-1:0]    s2_v_next      [NUM_AXES];
    logic [V_W-1:0]           abs_v          [NUM_AXES];
    logic [MAG_W-1:0]         s3_mag_reg     [NUM_AXES];
    logic [MAG_W-1:0]         s3_mag_next    [NUM_AXES];
    logic [MAG_W-1:0]         mag_or;
    logic [SH_W-1:0]          shift_amt;
    logic [A_W-1:0]           s4_a_reg       [NUM_AXES];
    logic [A_W-1:0]           s4_a_next      [NUM_AXES];
    sq_vec_t                  s5_sq_reg, s5_sq_next;
    sq_vec_t                  s6_sq_reg;
    logic [SUM_W-1:0]         s6_sum_reg, s6_sum_next;

    // Back end.
    ray_ctl_t          div_ctl, sqrt_ctl;
    quo_vec_t          div_quo;
    root_vec_t         sqrt_root;
    logic [ROOT_W:0]   root_inc   [NUM_AXES];
    logic [OUT_W-1:0]  out_mag    [NUM_AXES];
    logic [OUT_W-1:0]  out_val    [NUM_AXES];
    logic              done_reg;
    ray_dir_t          result_reg, result_next;

    // Configuration writes; an index past the last register is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_offset_reg <= '0;
            step_right_reg  <= '0;
            step_down_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE_OFFSET: base_offset_reg <= cfg_data;
                REG_STEP_RIGHT:  step_right_reg  <= cfg_data;
                REG_STEP_DOWN:   step_down_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Stage 1: per-axis products of the step vectors with the pixel position.
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            comp_base[i]  = $signed(base_offset_reg[i*COMP_W +: COMP_W]);
            comp_right[i] = $signed(step_right_reg[i*COMP_W +: COMP_W]);
            comp_down[i]  = $signed(step_down_reg[i*COMP_W +: COMP_W]);
            s1_prod_r_next[i] = PROD_W'(comp_right[i])
                              * PROD_W'($signed({1'b0, request.column_pos}));
            s1_prod_d_next[i] = PROD_W'(comp_down[i])
                              * PROD_W'($signed({1'b0, request.row_pos}));
        end
    end

    // Stage 2: ray vector in units of 2^-18.
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
            s2_v_next[i] = V_W'(s1_prod_r_reg[i]) + V_W'(s1_prod_d_reg[i])
                         + (V_W'(comp_base[i]) <<< FRAC_SHIFT);
    end

    // Stage 3: split each component into sign and magnitude.
    always_comb
    begin
        s3_ctl_next = s2_ctl_reg;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            s3_ctl_next.neg[i] = s2_v_reg[i][V_W-1];
            abs_v[i]           = s2_v_reg[i][V_W-1] ? V_W'(-s2_v_reg[i]) : V_W'(s2_v_reg[i]);
            s3_mag_next[i]     = abs_v[i][MAG_W-1:0];
        end
    end

    // Stage 4: common right shift that brings every magnitude below 2^30.
    always_comb
    begin
        mag_or    = s3_mag_reg[0] | s3_mag_reg[1] | s3_mag_reg[2];
        shift_amt = '0;
        for (int b = 0; b < MAG_W - A_W; b++)
        begin
            if (mag_or[A_W + b])
                shift_amt = SH_W'(b + 1);
        end
        s4_ctl_next      = s3_ctl_reg;
        s4_ctl_next.zero = (mag_or == '0);
        for (int i = 0; i < NUM_AXES; i++)
            s4_a_next[i] = A_W'(s3_mag_reg[i] >> shift_amt);
    end

    // Stage 5: squares; stage 6: sum of squares.
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
            s5_sq_next[i] = SQ_W'(s4_a_reg[i]) * SQ_W'(s4_a_reg[i]);
        s6_sum_next = SUM_W'(s5_sq_reg[0]) + SUM_W'(s5_sq_reg[1]) + SUM_W'(s5_sq_reg[2]);
    end

    // Front-end valid and sign bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
            s4_ctl_reg <= '0;
            s5_ctl_reg <= '0;
            s6_ctl_reg <= '0;
        end
        else
        begin
            s1_ctl_reg <= '{valid: start, zero: 1'b0, neg: '0};
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s3_ctl_next;
            s4_ctl_reg <= s4_ctl_next;
            s5_ctl_reg <= s4_ctl_reg;
            s6_ctl_reg <= s5_ctl_reg;
        end
    end

    // Front-end data.
    always_ff @(posedge clk)
    begin
        s1_prod_r_reg <= s1_prod_r_next;
        s1_prod_d_reg <= s1_prod_d_next;
        s2_v_reg      <= s2_v_next;
        s3_mag_reg    <= s3_mag_next;
        s4_a_reg      <= s4_a_next;
        s5_sq_reg     <= s5_sq_next;
        s6_sq_reg     <= s5_sq_reg;
        s6_sum_reg    <= s6_sum_next;
    end

    // Quotient floor(a^2 * 2^30 / S) per axis.
    crd_div_pipe u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (s6_ctl_reg),
        .in_sq   (s6_sq_reg),
        .in_sum  (s6_sum_reg),
        .out_ctl (div_ctl),
        .out_quo (div_quo)
    );

    // Integer square root of the quotient per axis.
    crd_sqrt_pipe u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctl   (div_ctl),
        .in_quo   (div_quo),
        .out_ctl  (sqrt_ctl),
        .out_root (sqrt_root)
    );

    // The output is the largest n with 2n-1 not above the root, with the sign applied; a zero ray gives zero.
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            root_inc[i] = (ROOT_W+1)'(sqrt_root[i]) + (ROOT_W+1)'(1);
            out_mag[i]  = OUT_W'(root_inc[i] >> 1);
            if (sqrt_ctl.zero)
                out_val[i] = '0;
            else if (sqrt_ctl.neg[i])
                out_val[i] = OUT_W'(0) - out_mag[i];
            else
                out_val[i] = out_mag[i];
        end
        result_next.dir_x = $signed(out_val[0]);
        result_next.dir_y = $signed(out_val[1]);
        result_next.dir_z = $signed(out_val[2]);
    end

    // Output register and strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= sqrt_ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

[rtl/crd_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, three lanes wide.
// Computes floor(sq * 2^30 / sum) per axis; depends on crd_pkg.
module crd_div_pipe (
    input  logic                        clk,
    input  logic                        rst_n,
    input  crd_pkg::ray_ctl_t           in_ctl,
    input  crd_pkg::sq_vec_t            in_sq,
    input  logic [crd_pkg::SUM_W-1:0]   in_sum,
    output crd_pkg::ray_ctl_t           out_ctl,
    output crd_pkg::quo_vec_t           out_quo
);
    import crd_pkg::*;

    logic [NUM_AXES-1:0][SUM_W-1:0] rem_reg  [QUO_W];
    logic [NUM_AXES-1:0][SUM_W-1:0] rem_next [QUO_W];
    quo_vec_t                       quo_reg  [QUO_W];
    quo_vec_t                       quo_next [QUO_W];
    logic [SUM_W-1:0]               sum_reg  [QUO_W];
    logic [SUM_W-1:0]               sum_next [QUO_W];
    ray_ctl_t                       ctl_reg  [QUO_W];
    ray_ctl_t                       ctl_next [QUO_W];

    logic [SUM_W-1:0] sum_in;
    ray_ctl_t         ctl_in;
    logic [SUM_W:0]   trial;
    logic [QUO_W-1:0] quo_in;
    logic             take;

    // Each stage doubles the partial remainder and subtracts the divisor when it fits.
    // The first stage decides the top quotient bit on the plain dividend.
    always_comb
    begin
        sum_in = '0;
        ctl_in = '0;
        trial  = '0;
        quo_in = '0;
        take   = 1'b0;
        for (int k = 0; k < QUO_W; k++)
        begin
            if (k == 0)
            begin
                sum_in = in_sum;
                ctl_in = in_ctl;
            end
            else
            begin
                sum_in = sum_reg[k-1];
                ctl_in = ctl_reg[k-1];
            end
            sum_next[k] = sum_in;
            ctl_next[k] = ctl_in;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                if (k == 0)
                begin
                    trial  = (SUM_W+1)'(in_sq[i]);
                    quo_in = '0;
                end
                else
                begin
                    trial  = {rem_reg[k-1][i], 1'b0};
                    quo_in = quo_reg[k-1][i];
                end
                take = (trial >= (SUM_W+1)'(sum_in));
                rem_next[k][i] = take ? SUM_W'(trial - (SUM_W+1)'(sum_in)) : SUM_W'(trial);
                quo_next[k][i] = {quo_in[QUO_W-2:0], take};
            end
        end
    end

    // Control registers of every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QUO_W; k++)
                ctl_reg[k] <= '0;
        end
        else
        begin
            for (int k = 0; k < QUO_W; k++)
                ctl_reg[k] <= ctl_next[k];
        end
    end

    // Data registers of every stage.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < QUO_W; k++)
        begin
            rem_reg[k] <= rem_next[k];
            quo_reg[k] <= quo_next[k];
            sum_reg[k] <= sum_next[k];
        end
    end

    assign out_ctl = ctl_reg[QUO_W-1];
    assign out_quo = quo_reg[QUO_W-1];

endmodule

[rtl/crd_sqrt_pipe.sv]
// Pipelined digit-by-digit integer square root, one root bit per stage, three lanes.
// Computes floor(sqrt(quo)) per axis; depends on crd_pkg.
module crd_sqrt_pipe (
    input  logic               clk,
    input  logic               rst_n,
    input  crd_pkg::ray_ctl_t  in_ctl,
    input  crd_pkg::quo_vec_t  in_quo,
    output crd_pkg::ray_ctl_t  out_ctl,
    output crd_pkg::root_vec_t out_root
);
    import crd_pkg::*;

    logic [NUM_AXES-1:0][RAD_W-1:0] rad_reg   [ROOT_W];
    logic [NUM_AXES-1:0][RAD_W-1:0] rad_next  [ROOT_W];
    logic [NUM_AXES-1:0][REM_W-1:0] rem_reg   [ROOT_W];
    logic [NUM_AXES-1:0][REM_W-1:0] rem_next  [ROOT_W];
    root_vec_t                      root_reg  [ROOT_W];
    root_vec_t                      root_next [ROOT_W];
    ray_ctl_t                       ctl_reg   [ROOT_W];
    ray_ctl_t                       ctl_next  [ROOT_W];

    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    // Each stage brings down the next two radicand bits and tries the next root bit.
    always_comb
    begin
        rad_in  = '0;
        rem_in  = '0;
        root_in = '0;
        rem_sh  = '0;
        trial   = '0;
        take    = 1'b0;
        for (int k = 0; k < ROOT_W; k++)
        begin
            if (k == 0)
                ctl_next[k] = in_ctl;
            else
                ctl_next[k] = ctl_reg[k-1];
            for (int i = 0; i < NUM_AXES; i++)
            begin
                if (k == 0)
                begin
                    rad_in  = RAD_W'(in_quo[i]);
                    rem_in  = '0;
                    root_in = '0;
                end
                else
                begin
                    rad_in  = rad_reg[k-1][i];
                    rem_in  = rem_reg[k-1][i];
                    root_in = root_reg[k-1][i];
                end
                rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
                trial  = {root_in, 2'b01};
                take   = (rem_sh >= trial);
                rem_next[k][i]  = take ? (rem_sh - trial) : rem_sh;
                root_next[k][i] = {root_in[ROOT_W-2:0], take};
                rad_next[k][i]  = {rad_in[RAD_W-3:0], 2'b00};
            end
        end
    end

    // Control registers of every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ROOT_W; k++)
                ctl_reg[k] <= '0;
        end
        else
        begin
            for (int k = 0; k < ROOT_W; k++)
                ctl_reg[k] <= ctl_next[k];
        end
    end

    // Data registers of every stage.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < ROOT_W; k++)
        begin
            rad_reg[k]  <= rad_next[k];
            rem_reg[k]  <= rem_next[k];
            root_reg[k] <= root_next[k];
        end
    end

    assign out_ctl  = ctl_reg[ROOT_W-1];
    assign out_root = root_reg[ROOT_W-1];

endmodule

[rtl/crd_port_chk.sv]
// Port-level checks for the camera ray direction block, with the bind that attaches them.
// Depends on crd_pkg and the top-level module camera_ray_direction.
module crd_port_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input crd_pkg::ray_dir_t result
);
    import crd_pkg::*;

    // The block takes a transaction in every cycle.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised although the pipeline never stalls");

    // Every accepted transaction comes out as a done strobe at the end of the pipeline.
    a_done_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LAT done)
        else $error("result strobe missing after an accepted transaction");

    // No result strobe without a matching accepted transaction at the head of the pipeline.
    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##PIPE_LAT !done)
        else $error("result strobe without an accepted transaction");

    // Every component of a unit vector lies within plus or minus one.
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.dir_x >= -ONE_Q14 && result.dir_x <= ONE_Q14 &&
                  result.dir_y >= -ONE_Q14 && result.dir_y <= ONE_Q14 &&
                  result.dir_z >= -ONE_Q14 && result.dir_z <= ONE_Q14))
        else $error("direction component outside the unit range");

endmodule

bind camera_ray_direction crd_port_chk u_port_chk (.*);
